/* design/hdsi_pkg.sv */
// Shared types for the hex/decimal string to integer converter.
`default_nettype none

package hdsi_pkg;

    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_ZERO     = 3'd1,
        MODE_HEXFIRST = 3'd2,
        MODE_HEX      = 3'd3,
        MODE_DEC      = 3'd4,
        MODE_SKIP     = 3'd5
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [3:0]  pos;
        logic [31:0] acc;
    } parse_state_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] value;
        logic        value_written;
    } result_t;

    localparam logic [3:0] LAST_POS = 4'd11;

endpackage

`default_nettype wire

/* design/hdsi_if.sv */
// Valid/ready channel interfaces for the character input and the result output.
`default_nettype none

interface hdsi_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface hdsi_result_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] value;
    logic        value_written;

    modport source (output valid, output ok, output value, output value_written, input ready);
    modport sink (input valid, input ok, input value, input value_written, output ready);
endinterface

`default_nettype wire

/* design/hdsi_step.sv */
// Per-character parse step: next parser state and the optional result.
`default_nettype none

module hdsi_step
    import hdsi_pkg::*;
(
    input  logic [7:0]   char_code,
    input  parse_state_t cur,
    output parse_state_t nxt,
    output logic         emit,
    output result_t      res
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_K  = 8'h6b;
    localparam logic [7:0] CH_UP_K  = 8'h4b;
    localparam logic [7:0] CH_LO_M  = 8'h6d;
    localparam logic [7:0] CH_UP_M  = 8'h4d;
    localparam int         SHIFT_K  = 10;
    localparam int         SHIFT_M  = 20;

    logic        is_nul;
    logic        is_dec;
    logic        is_alpha_hex;
    logic        is_k;
    logic        is_m;
    logic [3:0]  hex_d;
    logic [3:0]  pos_inc;
    logic [31:0] dec_acc;
    logic [31:0] hex_acc;
    logic        run_dec;
    logic        run_hex;

    assign is_nul       = (char_code == CH_NUL);
    assign is_dec       = char_code inside {[CH_ZERO:CH_NINE]};
    assign is_alpha_hex = char_code inside {[CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]};
    assign is_k         = (char_code == CH_LO_K) || (char_code == CH_UP_K);
    assign is_m         = (char_code == CH_LO_M) || (char_code == CH_UP_M);
    // letters a-f / A-F have low nibble 1..6
    assign hex_d        = is_dec ? char_code[3:0] : char_code[3:0] + 4'd9;
    assign pos_inc      = cur.pos + 4'd1;
    assign dec_acc      = (cur.acc << 3) + (cur.acc << 1) + {28'd0, char_code[3:0]};
    assign hex_acc      = {cur.acc[27:0], hex_d};

    always_comb
    begin
        nxt     = cur;
        emit    = 1'b0;
        res     = '0;
        run_dec = 1'b0;
        run_hex = 1'b0;

        case (cur.mode)
            MODE_START:
            begin
                if (char_code == CH_ZERO)
                begin
                    nxt.mode = MODE_ZERO;
                    nxt.pos  = 4'd1;
                    nxt.acc  = '0;
                end
                else
                begin
                    run_dec = 1'b1;
                end
            end
            MODE_ZERO:
            begin
                if ((char_code == CH_LO_X) || (char_code == CH_UP_X))
                begin
                    nxt.mode = MODE_HEXFIRST;
                    nxt.pos  = 4'd2;
                end
                else
                begin
                    run_dec = 1'b1;
                end
            end
            MODE_HEXFIRST:
            begin
                if (is_nul)
                begin
                    // bare prefix: fail without a value
                    nxt  = '{MODE_START, 4'd0, 32'd0};
                    emit = 1'b1;
                end
                else
                begin
                    run_hex = 1'b1;
                end
            end
            MODE_HEX:
            begin
                run_hex = 1'b1;
            end
            MODE_DEC:
            begin
                run_dec = 1'b1;
            end
            default:
            begin
                if (is_nul)
                    nxt = '{MODE_START, 4'd0, 32'd0};
                else
                    nxt.mode = MODE_SKIP;
            end
        endcase

        if (run_dec)
        begin
            emit = 1'b1;
            if (is_nul)
            begin
                nxt = '{MODE_START, 4'd0, 32'd0};
                res = '{1'b1, cur.acc, 1'b1};
            end
            else if (is_k && (cur.pos != 4'd0))
            begin
                nxt.mode = MODE_SKIP;
                res      = '{1'b1, cur.acc << SHIFT_K, 1'b1};
            end
            else if (is_m && (cur.pos != 4'd0))
            begin
                nxt.mode = MODE_SKIP;
                res      = '{1'b1, cur.acc << SHIFT_M, 1'b1};
            end
            else if (is_dec)
            begin
                nxt.acc = dec_acc;
                nxt.pos = pos_inc;
                if (pos_inc >= LAST_POS)
                begin
                    nxt.mode = MODE_SKIP;
                end
                else
                begin
                    nxt.mode = MODE_DEC;
                    emit     = 1'b0;
                end
            end
            else
            begin
                nxt.mode = MODE_SKIP;
                res      = '{1'b0, cur.acc, 1'b1};
            end
        end

        if (run_hex)
        begin
            emit = 1'b1;
            if (is_nul)
            begin
                nxt = '{MODE_START, 4'd0, 32'd0};
                res = '{1'b1, cur.acc, 1'b1};
            end
            else if (is_dec || is_alpha_hex)
            begin
                nxt.acc = hex_acc;
                nxt.pos = pos_inc;
                if (pos_inc >= LAST_POS)
                begin
                    nxt.mode = MODE_SKIP;
                end
                else
                begin
                    nxt.mode = MODE_HEX;
                    emit     = 1'b0;
                end
            end
            else
            begin
                nxt.mode = MODE_SKIP;
                res      = '{1'b0, cur.acc, 1'b1};
            end
        end
    end

endmodule

`default_nettype wire

/* design/hex_dec_string_to_integer_top.sv */
// Top level of the hex/decimal ASCII string to 32-bit integer converter.
//
//  channel   dir  payload                          beat
//  chars     in   char_code[7:0]                   one character, zero ends string
//  results   out  ok, value[31:0], value_written   at most one per string
//
// One character per cycle unless results stall; each beat waits in the input
// register; its result, if any, is loaded into the result register on advance.
// Reset clears the parser to start of string and empties both registers.
// A stalled result register holds the input register; the input side keeps
// taking beats whenever the input register is empty or moving on.
`default_nettype none

module hex_dec_string_to_integer_top
    import hdsi_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    hdsi_char_if.sink    chars,
    hdsi_result_if.source results
);

    logic         in_valid_reg;
    logic [7:0]   char_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    result_t      out_reg;
    result_t      res_next;
    logic         emit;
    logic         advance;

    assign advance     = in_valid_reg && (!out_valid_reg || results.ready);
    assign chars.ready = !in_valid_reg || advance;

    hdsi_step u_step (
        .char_code (char_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .emit      (emit),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{MODE_START, 4'd0, 32'd0};
        end
        else
        begin
            if (chars.ready)
                in_valid_reg <= chars.valid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= emit;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
            char_reg <= chars.char_code;
        if (advance && emit)
            out_reg <= res_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.ok            = out_reg.ok;
    assign results.value         = out_reg.value;
    assign results.value_written = out_reg.value_written;

    // string position never runs past the overlength limit
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pos <= LAST_POS)
        else $error("string position beyond limit");

    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode == MODE_START |-> (state_reg.pos == 4'd0 && state_reg.acc == 32'd0))
        else $error("start of string with stale position or value");

    a_unwritten_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.value_written) |-> (!results.ok && results.value == 32'd0))
        else $error("unwritten result not a clean failure");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !results.ready) |=> in_valid_reg && $stable(char_reg))
        else $error("input beat lost under output stall");

endmodule

`default_nettype wire
